FILE: design/bhte_pkg.sv
// shared types, codes and defaults for the bucketed hash table engine
// no dependencies; imported by bhte_ctrl, bhte_dp and the top level
`default_nettype none

package bhte_pkg;

    localparam int KEY_BITS      = 56;
    localparam int DATA_BITS     = 64;
    localparam int LOW_WORD_BITS = 32;

    localparam int ROW_INDEX_BITS_DEF = 10;
    localparam int SLOTS_PER_ROW_DEF  = 8;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic                 kind;
        logic [KEY_BITS-1:0]  key_hash;
        logic [DATA_BITS-1:0] entry_data;
    } bhte_req_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] match_data;
        logic [1:0]           status;
        logic                 last;
    } bhte_resp_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic capture;
        logic insert;
        logic reject;
        logic scan;
        logic finish;
    } bhte_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic kind;
        logic full;
        logic scan_done;
    } bhte_stat_t;

endpackage

`default_nettype wire

FILE: design/bhte_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module bhte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/bhte_ctrl.sv
// controller state machine of the hash table engine
// depends on bhte_pkg; drives bhte_dp through bhte_cmd_t
`default_nettype none

module bhte_ctrl
    import bhte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire bhte_stat_t stat,
    output bhte_cmd_t       cmd,
    output logic            busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_DECIDE,
        S_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.kind == KIND_INSERT)
                begin
                    cmd.reject = stat.full;
                    cmd.insert = !stat.full;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: design/bhte_dp.sv
// datapath: row fill memory, slot memory, tag compare and result register
// depends on bhte_pkg and bhte_ram; steered by bhte_ctrl
`default_nettype none

module bhte_dp
    import bhte_pkg::*;
#(
    parameter int ROW_INDEX_BITS = ROW_INDEX_BITS_DEF,
    parameter int SLOTS_PER_ROW  = SLOTS_PER_ROW_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire bhte_req_t  request,
    input  wire bhte_cmd_t  cmd,
    output bhte_stat_t      stat,
    output bhte_resp_t      response,
    output logic            response_valid
);

    localparam int RIB = ROW_INDEX_BITS;
    localparam int FW  = $clog2(SLOTS_PER_ROW + 1);
    localparam int SB  = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
    localparam int TW  = KEY_BITS - RIB;
    localparam int SW  = TW + DATA_BITS;

    // latched item
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic                 kind_reg;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        slot_reg, slot_next;
    logic [DATA_BITS-1:0] buf_data_reg, buf_data_next;
    logic                 buf_valid_reg, buf_valid_next;
    logic                 pend_reg, pend_next;
    logic [RIB-1:0]       clr_cnt_reg, clr_cnt_next;
    bhte_resp_t           resp_reg, resp_next;
    logic                 resp_valid_reg, resp_valid_next;

    logic [RIB-1:0]       row;
    logic [TW-1:0]        tag;
    logic                 more;
    logic                 hit;

    logic                 fill_wr_en;
    logic [RIB-1:0]       fill_wr_addr;
    logic [FW-1:0]        fill_wr_data;
    logic [FW-1:0]        fill_rd_data;
    logic                 slot_rd_en;
    logic [SW-1:0]        slot_rd_data;

    assign row = key_reg[LOW_WORD_BITS +: RIB];

    // tag keeps the low word and whatever sits above the row index
    generate
        if (TW == LOW_WORD_BITS)
        begin : g_tag_low
            assign tag = key_reg[LOW_WORD_BITS-1:0];
        end
        else
        begin : g_tag_split
            assign tag = {key_reg[KEY_BITS-1:LOW_WORD_BITS+RIB],
                          key_reg[LOW_WORD_BITS-1:0]};
        end
    endgenerate

    assign more = (slot_reg < fill_reg);
    assign hit  = pend_reg && (slot_rd_data[SW-1:DATA_BITS] == tag);

    assign fill_wr_en   = cmd.clr_step || cmd.insert;
    assign fill_wr_addr = cmd.clr_step ? clr_cnt_reg : row;
    assign fill_wr_data = cmd.clr_step ? '0 : fill_reg + FW'(1);
    assign slot_rd_en   = cmd.scan && more;

    bhte_ram #(
        .WIDTH (FW),
        .DEPTH (1 << RIB)
    ) u_fill_ram (
        .clk     (clk),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .rd_en   (cmd.load),
        .rd_addr (request.key_hash[LOW_WORD_BITS +: RIB]),
        .rd_data (fill_rd_data)
    );

    bhte_ram #(
        .WIDTH (SW),
        .DEPTH (1 << (RIB + SB))
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (cmd.insert),
        .wr_addr ({row, fill_reg[SB-1:0]}),
        .wr_data ({tag, data_reg}),
        .rd_en   (slot_rd_en),
        .rd_addr ({row, slot_reg[SB-1:0]}),
        .rd_data (slot_rd_data)
    );

    always_comb
    begin
        fill_next       = fill_reg;
        slot_next       = slot_reg;
        buf_data_next   = buf_data_reg;
        buf_valid_next  = buf_valid_reg;
        pend_next       = pend_reg;
        clr_cnt_next    = clr_cnt_reg;
        resp_next       = resp_reg;
        resp_valid_next = 1'b0;

        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + RIB'(1);
        end
        if (cmd.load)
        begin
            slot_next      = '0;
            buf_valid_next = 1'b0;
            pend_next      = 1'b0;
        end
        if (cmd.capture)
        begin
            fill_next = fill_rd_data;
        end
        if (cmd.insert)
        begin
            resp_next       = '{match_data: '0, status: ST_INSERTED, last: 1'b1};
            resp_valid_next = 1'b1;
        end
        if (cmd.reject)
        begin
            resp_next       = '{match_data: '0, status: ST_FULL, last: 1'b1};
            resp_valid_next = 1'b1;
        end
        if (cmd.scan)
        begin
            pend_next = more;
            if (more)
            begin
                slot_next = slot_reg + FW'(1);
            end
            // a match is held back in the buffer until we know whether another follows
            if (hit)
            begin
                if (buf_valid_reg)
                begin
                    resp_next       = '{match_data: buf_data_reg, status: ST_MATCH, last: 1'b0};
                    resp_valid_next = 1'b1;
                end
                buf_data_next  = slot_rd_data[DATA_BITS-1:0];
                buf_valid_next = 1'b1;
            end
        end
        if (cmd.finish)
        begin
            if (buf_valid_reg)
            begin
                resp_next = '{match_data: buf_data_reg, status: ST_MATCH, last: 1'b1};
            end
            else
            begin
                resp_next = '{match_data: '0, status: ST_NO_MATCH, last: 1'b1};
            end
            resp_valid_next = 1'b1;
            buf_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            clr_cnt_reg    <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg  <= buf_valid_next;
            pend_reg       <= pend_next;
            clr_cnt_reg    <= clr_cnt_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= request.key_hash;
            data_reg <= request.entry_data;
            kind_reg <= request.kind;
        end
        fill_reg     <= fill_next;
        slot_reg     <= slot_next;
        buf_data_reg <= buf_data_next;
        resp_reg     <= resp_next;
    end

    assign stat.clr_last  = &clr_cnt_reg;
    assign stat.kind      = kind_reg;
    assign stat.full      = (fill_reg >= FW'(SLOTS_PER_ROW));
    assign stat.scan_done = !more && !pend_reg;

    assign response       = resp_reg;
    assign response_valid = resp_valid_reg;

endmodule

`default_nettype wire

FILE: design/bucketed_hash_table_engine.sv
// top level of the bucketed hash table engine
// depends on bhte_pkg, bhte_ctrl, bhte_dp (which holds two bhte_ram instances)
`default_nettype none

// An item is taken when start is high and busy is low. Each result appears for
// one cycle with response_valid high and must be taken then; there is no way to
// hold results off. After reset the row fill memory is cleared one row per cycle,
// every row in turn, while busy stays high. An insert returns one result. A
// lookup reads the row's filled slots one slot per cycle through the single read
// port of the slot memory; matches come out in slot order, at most one per cycle,
// the final one marked by last.

module bucketed_hash_table_engine
    import bhte_pkg::*;
#(
    parameter int ROW_INDEX_BITS = ROW_INDEX_BITS_DEF,
    parameter int SLOTS_PER_ROW  = SLOTS_PER_ROW_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire bhte_req_t  request,
    output logic            response_valid,
    output bhte_resp_t      response
);

    bhte_cmd_t  cmd;
    bhte_stat_t stat;

    bhte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bhte_dp #(
        .ROW_INDEX_BITS (ROW_INDEX_BITS),
        .SLOTS_PER_ROW  (SLOTS_PER_ROW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (request),
        .cmd            (cmd),
        .stat           (stat),
        .response       (response),
        .response_valid (response_valid)
    );

`ifndef SYNTHESIS
    // a taken item keeps the block busy until its work is done
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an item was taken");

    // only a match can be followed by further results
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (response_valid && (response.status != ST_MATCH)) |-> response.last)
        else $error("non-match result without last");

    // the final result of an item is never directly followed by another result
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (response_valid && response.last) |=> !response_valid)
        else $error("result directly after the final result of an item");

    // no result while the block is idle and has not been given an item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> (!response_valid || $past(busy)))
        else $error("result without an item in progress");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench for the bucketed hash table engine: directed and random inserts and lookups,
// each result checked in order against a table model; depends on bhte_pkg and the top level

module tb_top;
    import bhte_pkg::*;

    localparam int ROW_BITS    = 10;
    localparam int SLOTS       = 8;
    localparam int ROWS        = 1 << ROW_BITS;
    localparam int TAG_BITS    = KEY_BITS - ROW_BITS;
    localparam int CLK_PERIOD  = 12;
    localparam int HALF_PERIOD = CLK_PERIOD / 2;
    localparam int POOL_KEYS   = 12;
    localparam int POOL_ROWS   = 4;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    bhte_req_t  request;
    logic       response_valid;
    bhte_resp_t response;

    // table model
    logic [3:0]           fill_count     [ROWS];
    logic [TAG_BITS-1:0]  stored_tag     [ROWS][SLOTS];
    logic [DATA_BITS-1:0] stored_payload [ROWS][SLOTS];
    bhte_resp_t           pending_responses[$];

    int error_count     = 0;
    int sender_idle_pct = 0;

    bucketed_hash_table_engine #(
        .ROW_INDEX_BITS(ROW_BITS),
        .SLOTS_PER_ROW (SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .response_valid(response_valid),
        .response      (response)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [ROW_BITS-1:0] row_of_key(input logic [KEY_BITS-1:0] key);
        return key[LOW_WORD_BITS +: ROW_BITS];
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_of_key(input logic [KEY_BITS-1:0] key);
        return {key[KEY_BITS-1:LOW_WORD_BITS+ROW_BITS], key[LOW_WORD_BITS-1:0]};
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_key();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[KEY_BITS-1:0];
    endfunction

    function automatic logic [DATA_BITS-1:0] rand_data();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v;
    endfunction

    function automatic bhte_req_t make_req(input logic kind, input logic [KEY_BITS-1:0] key,
                                           input logic [DATA_BITS-1:0] data);
        bhte_req_t it;
        it.kind       = kind;
        it.key_hash   = key;
        it.entry_data = data;
        return it;
    endfunction

    // updates the table model and queues the results the item causes
    function automatic void apply_table_op(input bhte_req_t it);
        logic [ROW_BITS-1:0] row;
        logic [TAG_BITS-1:0] tag;
        bhte_resp_t          r;
        int                  hits;
        row  = row_of_key(it.key_hash);
        tag  = tag_of_key(it.key_hash);
        hits = 0;
        r.match_data = '0;
        r.last       = 1'b1;
        if (it.kind == KIND_INSERT) begin
            if (fill_count[row] >= SLOTS) begin
                r.status = ST_FULL;
            end else begin
                stored_tag[row][fill_count[row]]     = tag;
                stored_payload[row][fill_count[row]] = it.entry_data;
                fill_count[row]                      = fill_count[row] + 4'd1;
                r.status                             = ST_INSERTED;
            end
            pending_responses.push_back(r);
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (i < int'(fill_count[row]) && stored_tag[row][i] == tag) begin
                    r.match_data = stored_payload[row][i];
                    r.status     = ST_MATCH;
                    r.last       = 1'b0;
                    pending_responses.push_back(r);
                    hits++;
                end
            end
            if (hits == 0) begin
                r.match_data = '0;
                r.status     = ST_NO_MATCH;
                r.last       = 1'b1;
                pending_responses.push_back(r);
            end else begin
                // final match of the lookup carries last
                r      = pending_responses.pop_back();
                r.last = 1'b1;
                pending_responses.push_back(r);
            end
        end
    endfunction

    always @(posedge clk) begin : check_results
        bhte_resp_t want;
        if (rst_n && response_valid) begin
            if (pending_responses.size() == 0) begin
                $error("unexpected result: match_data %h status %0d last %0b",
                       response.match_data, response.status, response.last);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                if (response.match_data !== want.match_data) begin
                    $error("match_data expected %h actual %h",
                           want.match_data, response.match_data);
                    error_count++;
                end
                if (response.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, response.status);
                    error_count++;
                end
                if (response.last !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, response.last);
                    error_count++;
                end
            end
        end
    end

    // returns at the edge where the item is taken; start stays high for a follow-on item
    task automatic send_item(input bhte_req_t it);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        apply_table_op(it);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [KEY_BITS-1:0] base;
        logic [KEY_BITS-1:0] ones;
        base = {14'h2a5c, ROW_BITS'(5), 32'h1234_5678};
        ones = '1;
        // lookups into empty rows, extremes of the key
        send_item(make_req(KIND_LOOKUP, '0, '0));
        send_item(make_req(KIND_LOOKUP, ones, '1));
        send_item(make_req(KIND_INSERT, '0, '0));
        send_item(make_req(KIND_INSERT, ones, '1));
        send_item(make_req(KIND_LOOKUP, '0, '1));
        send_item(make_req(KIND_LOOKUP, ones, '0));
        // fill one row: equal keys and near misses on both ends of the tag
        send_item(make_req(KIND_INSERT, base, rand_data()));
        send_item(make_req(KIND_INSERT, base, rand_data()));
        send_item(make_req(KIND_INSERT, base, rand_data()));
        send_item(make_req(KIND_INSERT, base ^ (56'd1 << 55), rand_data()));
        send_item(make_req(KIND_INSERT, base ^ 56'd1, rand_data()));
        send_item(make_req(KIND_INSERT, base ^ (56'd1 << 31), rand_data()));
        send_item(make_req(KIND_INSERT, base ^ (56'd1 << (LOW_WORD_BITS + ROW_BITS)),
                           rand_data()));
        send_item(make_req(KIND_INSERT, {14'h0001, ROW_BITS'(5), 32'hdead_beef}, rand_data()));
        // row is full now
        send_item(make_req(KIND_INSERT, base, rand_data()));
        wait_drain();
        send_item(make_req(KIND_LOOKUP, base, rand_data()));
        send_item(make_req(KIND_LOOKUP, base ^ (56'd1 << 55), rand_data()));
        send_item(make_req(KIND_LOOKUP, base ^ (56'd1 << 30), rand_data()));
        // same tag in the neighboring row
        send_item(make_req(KIND_LOOKUP, base ^ (56'd1 << LOW_WORD_BITS), rand_data()));
        send_item(make_req(KIND_INSERT, base ^ 56'd1, rand_data()));
        send_item(make_req(KIND_LOOKUP, base ^ 56'd1, rand_data()));
    endtask

    task automatic test_random(input int items, input int idle_pct);
        logic [ROW_BITS-1:0] rows     [POOL_ROWS];
        logic [KEY_BITS-1:0] key_pool [POOL_KEYS];
        logic [KEY_BITS-1:0] k;
        bhte_req_t           it;
        int                  pick;
        int                  bit_idx;
        sender_idle_pct = idle_pct;
        foreach (rows[i]) rows[i] = ROW_BITS'($urandom_range(ROWS - 1));
        // keys crowd into a few rows so rows fill and lookups hit
        foreach (key_pool[i]) begin
            k = rand_key();
            k[LOW_WORD_BITS +: ROW_BITS] = rows[$urandom_range(POOL_ROWS - 1)];
            key_pool[i] = k;
        end
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            k    = key_pool[$urandom_range(POOL_KEYS - 1)];
            if (pick < 10) begin
                it = make_req(1'($urandom_range(1)), rand_key(), rand_data());
            end else if (pick < 50) begin
                it = make_req(KIND_INSERT, k, rand_data());
            end else begin
                if (pick >= 85) begin
                    bit_idx    = $urandom_range(KEY_BITS - 1);
                    k[bit_idx] = ~k[bit_idx];
                end
                it = make_req(KIND_LOOKUP, k, rand_data());
            end
            send_item(it);
        end
    endtask

    initial begin
        start   <= 1'b0;
        request <= '0;
        rst_n   <= 1'b0;
        foreach (fill_count[r]) fill_count[r] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        sender_idle_pct = 23;
        test_directed();
        test_random(65, 23);
        wait_drain();
        test_random(65, 85);
        wait_drain();
        test_random(65, 0);
        wait_drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("PASS bucketed_hash_table_engine");
        else
            $display("FAIL bucketed_hash_table_engine");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 200_000);
        $display("FAIL bucketed_hash_table_engine");
        $finish;
    end

endmodule
